[hdl/dcibs_pkg.sv]
`timescale 1ns / 1ps

package dcibs_pkg;

	localparam int unsigned FREQ_W    = 16;
	localparam int unsigned START_W   = 13;
	localparam int unsigned BLOCK_W   = 10;
	localparam int unsigned BRAKE_W   = 11;
	localparam int unsigned CNT_W     = 11;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 13;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		METH_RAMP  = 2'd0,
		METH_DCI   = 2'd1,
		METH_FREE  = 2'd2,
		METH_SPARE = 2'd3
	} method_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_METHOD = 2'd0,
		REG_START  = 2'd1,
		REG_BLOCK  = 2'd2,
		REG_BRAKE  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_BLOCK = 2'd1,
		PH_BRAKE = 2'd2,
		PH_OFF   = 2'd3
	} phase_t;

	typedef struct packed {
		method_t             method;
		logic [START_W-1:0]  start_freq;
		logic [BLOCK_W-1:0]  block_time;
		logic [BRAKE_W-1:0]  brake_time;
	} cfg_t;

	typedef struct packed {
		logic               decelerating;
		logic               stopped;
		logic               pwm_off_done;
		logic [FREQ_W-1:0]  target_freq;
		logic [FREQ_W-1:0]  present_freq;
		logic               tenth_tick;
	} item_t;

	typedef struct packed {
		phase_t  phase;
		logic    dci_active;
		logic    free_run;
	} result_t;

endpackage

[hdl/dc_injection_brake_sequencer.sv]
`timescale 1ns / 1ps

// dc injection brake sequencer: one result beat per input beat, one beat per clock
// sustained unless out_ready stalls. an input beat is captured in an input register,
// the phase update and free-run check run as a single combinational pass, and the
// result enters an output register as the beat advances; the phase and tick count
// update at that edge, so back-to-back beats see each other's state in order. the
// config port is always ready and should be written only while no beat is in flight.

module dc_injection_brake_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dcibs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dcibs_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            decelerating,
	input  logic                            stopped,
	input  logic                            pwm_off_done,
	input  logic [dcibs_pkg::FREQ_W-1:0]    target_freq,
	input  logic [dcibs_pkg::FREQ_W-1:0]    present_freq,
	input  logic                            tenth_tick,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      brake_phase,
	output logic                            dci_active,
	output logic                            free_run
);
	import dcibs_pkg::*;

	cfg_t     cfg;
	item_t    item_s1;
	logic     valid_s1;
	result_t  res_comb;
	result_t  res_s2;
	logic     valid_s2;
	logic     advance;

	assign cfg_ready = 1'b1;

	dcibs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{decelerating: decelerating, stopped: stopped,
				pwm_off_done: pwm_off_done, target_freq: target_freq,
				present_freq: present_freq, tenth_tick: tenth_tick};
		end
	end

	dcibs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.cfg     (cfg),
		.item    (item_s1),
		.res     (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid   = valid_s2;
	assign brake_phase = res_s2.phase;
	assign dci_active  = res_s2.dci_active;
	assign free_run    = res_s2.free_run;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted beat lost from input register");

	a_advance_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced beat lost from result register");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s2) |-> in_ready)
		else $error("input stalled with result register empty");

endmodule

[hdl/dcibs_cfg.sv]
`timescale 1ns / 1ps

module dcibs_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [dcibs_pkg::CFG_IDX_W-1:0] wr_idx,
	input  logic [dcibs_pkg::CFG_DAT_W-1:0] wr_data,
	output dcibs_pkg::cfg_t                 cfg
);
	import dcibs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{method: METH_RAMP, start_freq: '0, block_time: '0, brake_time: '0};
		end else if (wr_en) begin
			case (reg_idx_t'(wr_idx))
				REG_METHOD: cfg_q.method     <= method_t'(wr_data[1:0]);
				REG_START:  cfg_q.start_freq <= wr_data[START_W-1:0];
				REG_BLOCK:  cfg_q.block_time <= wr_data[BLOCK_W-1:0];
				REG_BRAKE:  cfg_q.brake_time <= wr_data[BRAKE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/dcibs_core.sv]
`timescale 1ns / 1ps

module dcibs_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  dcibs_pkg::cfg_t    cfg,
	input  dcibs_pkg::item_t   item,
	output dcibs_pkg::result_t res
);
	import dcibs_pkg::*;

	phase_t            phase_q, phase_d;
	logic [CNT_W-1:0]  elapsed_q, elapsed_d;
	logic [CNT_W-1:0]  elapsed_inc;
	logic              heading_to_zero;
	logic              dci;

	assign heading_to_zero = item.decelerating && (item.target_freq == '0)
		&& (item.present_freq != '0);
	assign dci = (cfg.method == METH_DCI);

	// saturating tick count
	assign elapsed_inc = (item.tenth_tick && elapsed_q != CNT_MAX) ?
		elapsed_q + CNT_W'(1) : elapsed_q;

	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		if (dci) begin
			case (phase_q)
				PH_IDLE: begin
					if (heading_to_zero &&
						item.present_freq <= FREQ_W'(cfg.start_freq)) begin
						phase_d   = PH_BLOCK;
						elapsed_d = '0;
					end
				end
				PH_BLOCK: begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= CNT_W'(cfg.block_time)) begin
						phase_d   = PH_BRAKE;
						elapsed_d = '0;
					end
				end
				PH_BRAKE: begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= cfg.brake_time) begin
						phase_d = PH_OFF;
					end
				end
				PH_OFF: begin
					if (item.pwm_off_done && item.stopped) begin
						phase_d = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
		end else if (step_en) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
		end
	end

	assign res.phase      = phase_d;
	assign res.dci_active = dci;
	assign res.free_run   = (cfg.method == METH_FREE) && heading_to_zero;

	a_frozen_unless_dci: assert property (@(posedge clk) disable iff (!arst_n)
		!(step_en && dci) |=> (phase_q == $past(phase_q) && elapsed_q == $past(elapsed_q)))
		else $error("sequencer moved without a dc injection step");

	a_block_entry_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && phase_q == PH_IDLE && phase_d == PH_BLOCK) |=> (elapsed_q == '0))
		else $error("count not cleared on entering block phase");

	a_brake_entry_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && phase_q == PH_BLOCK && phase_d == PH_BRAKE) |=> (elapsed_q == '0))
		else $error("count not cleared on entering brake phase");

endmodule
